// ===== hdl/u16d_pkg.sv =====
// u16d_pkg: shared constants for the utf-16 byte stream decoder
// used by the channel interfaces and the top level; no dependencies
`default_nettype none

package u16d_pkg;

	localparam int ByteW   = 8;
	localparam int UnitW   = 16;
	localparam int HeldW   = 24;
	localparam int CodeW   = 32;
	localparam int StatusW = 2;
	localparam int AddrW   = 3;
	localparam int DataW   = 32;

	localparam logic [StatusW-1:0] StatusOk        = 2'd0;
	localparam logic [StatusW-1:0] StatusMalformed = 2'd1;
	localparam logic [StatusW-1:0] StatusTruncated = 2'd2;

	localparam logic RegNative = 1'b0;

	localparam logic [UnitW-1:0] SurrMask   = 16'hF800;
	localparam logic [UnitW-1:0] SurrBase   = 16'hD800;
	localparam logic [UnitW-1:0] PairMask   = 16'hFC00;
	localparam logic [UnitW-1:0] LowBase    = 16'hDC00;
	localparam logic [CodeW-1:0] PlaneBase  = 32'h0001_0000;
	localparam logic [ByteW-1:0] BomFe      = 8'hFE;
	localparam logic [ByteW-1:0] BomFf      = 8'hFF;
	localparam logic             NativeRst  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/u16d_ifs.sv =====
// u16d_ifs: valid/ready channels for raw bytes in and code points out
// depends on u16d_pkg for field widths
`default_nettype none

interface u16d_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u16d_pkg::ByteW-1:0]    data_byte;
	logic                          end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u16d_cp_if;
	logic                          valid;
	logic                          ready;
	logic [u16d_pkg::CodeW-1:0]    code_point;
	logic [u16d_pkg::StatusW-1:0]  status;
	logic                          stream_done;

	modport source (output valid, output code_point, output status, output stream_done,
		input ready);
	modport sink   (input valid, input code_point, input status, input stream_done,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/utf16_byte_stream_decoder.sv =====
// utf16_byte_stream_decoder: utf-16 byte stream to code points, apb register for native order
// depends on u16d_pkg and the channel interfaces in u16d_ifs
`default_nettype none

// Takes one byte per cycle on byte_ch and returns decoded code points on cp_ch. A byte is
// latched into the input register, decoded against the small stream state once the decode
// stage advances, and lands in the result register. Throughput is one byte per cycle while
// cp_ch is taking results; the decode stage advances whenever the result register is empty
// or being read. A byte-order mark at stream start sets the order for that stream, otherwise
// native_little_endian (apb offset 0, bit 0, reset 1) applies. The last byte of a stream
// always yields a result with stream_done set.
module utf16_byte_stream_decoder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [u16d_pkg::AddrW-1:0]    paddr,
	input  wire [u16d_pkg::DataW-1:0]    pwdata,
	output logic [u16d_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	u16d_byte_if.sink                    byte_ch,
	u16d_cp_if.source                    cp_ch
);

	typedef enum logic [1:0] {
		PhIdle    = 2'd0,
		PhOneByte = 2'd1,
		PhHigh    = 2'd2,
		PhHighOne = 2'd3
	} phase_t;

	logic                           native_q;
	logic                           valid_s1;
	logic [u16d_pkg::ByteW-1:0]     byte_s1;
	logic                           eos_s1;
	logic                           adv_s1;

	phase_t                         phase_q,  phase_d;
	logic [u16d_pkg::HeldW-1:0]     held_q,   held_d;
	logic                           start_q,  start_d;
	logic                           active_q, active_d;

	logic                           emit;
	logic [u16d_pkg::CodeW-1:0]     code_d;
	logic [u16d_pkg::StatusW-1:0]   status_d;

	logic                           valid_s2;
	logic [u16d_pkg::CodeW-1:0]     code_s2;
	logic [u16d_pkg::StatusW-1:0]   status_s2;
	logic                           done_s2;

	logic                           reg_sel;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == u16d_pkg::RegNative);
	assign prdata  = reg_sel ? {{(u16d_pkg::DataW-1){1'b0}}, native_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_q <= u16d_pkg::NativeRst;
		end else if (psel && penable && pwrite && reg_sel) begin
			native_q <= pwdata[0];
		end
	end

	// input register
	assign adv_s1       = valid_s1 && (!valid_s2 || cp_ch.ready);
	assign byte_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data_byte;
			eos_s1  <= byte_ch.end_of_stream;
		end
	end

	// decode
	always_comb begin
		logic [u16d_pkg::ByteW-1:0] first;
		logic                       le;
		logic                       mark;
		logic [u16d_pkg::UnitW-1:0] unit;
		logic [u16d_pkg::UnitW-1:0] hi;
		logic [u16d_pkg::CodeW-1:0] lo_off;
		logic [u16d_pkg::CodeW-1:0] hi_off;

		phase_d  = phase_q;
		held_d   = held_q;
		start_d  = start_q;
		active_d = active_q;
		emit     = 1'b0;
		code_d   = '0;
		status_d = u16d_pkg::StatusOk;

		first  = (phase_q == PhOneByte) ? held_q[7:0] : held_q[7:0];
		mark   = 1'b0;
		le     = active_q;
		if (phase_q == PhOneByte && start_q) begin
			if (first == u16d_pkg::BomFe && byte_s1 == u16d_pkg::BomFf) begin
				le   = 1'b0;
				mark = 1'b1;
			end else if (first == u16d_pkg::BomFf && byte_s1 == u16d_pkg::BomFe) begin
				le   = 1'b1;
				mark = 1'b1;
			end else begin
				le = native_q;
			end
		end
		unit   = le ? {byte_s1, first} : {first, byte_s1};
		hi     = held_q[23:8];
		lo_off = {16'd0, unit} - {16'd0, u16d_pkg::LowBase};
		hi_off = ({16'd0, hi} - {16'd0, u16d_pkg::SurrBase}) << 10;

		case (phase_q)
			PhIdle: begin
				held_d  = {held_q[23:8], byte_s1};
				phase_d = PhOneByte;
			end
			PhOneByte: begin
				start_d  = 1'b0;
				active_d = le;
				phase_d  = PhIdle;
				if (!mark) begin
					if ((unit & u16d_pkg::SurrMask) != u16d_pkg::SurrBase) begin
						emit   = 1'b1;
						code_d = {16'd0, unit};
					end else if (unit[10]) begin
						emit     = 1'b1;
						code_d   = {16'd0, unit};
						status_d = u16d_pkg::StatusMalformed;
					end else begin
						held_d  = {unit, 8'd0};
						phase_d = PhHigh;
					end
				end
			end
			PhHigh: begin
				held_d  = {held_q[23:8], byte_s1};
				phase_d = PhHighOne;
			end
			PhHighOne: begin
				emit     = 1'b1;
				code_d   = u16d_pkg::PlaneBase + lo_off + hi_off;
				status_d = ((unit & u16d_pkg::PairMask) == u16d_pkg::LowBase) ?
					u16d_pkg::StatusOk : u16d_pkg::StatusMalformed;
				phase_d  = PhIdle;
				held_d   = '0;
			end
			default: begin
				phase_d = PhIdle;
			end
		endcase

		if (eos_s1) begin
			if (!emit) begin
				emit = 1'b1;
				if (phase_d == PhOneByte || phase_d == PhHighOne) begin
					status_d = u16d_pkg::StatusTruncated;
					code_d   = '0;
				end else if (phase_d == PhHigh) begin
					status_d = u16d_pkg::StatusMalformed;
					code_d   = {16'd0, held_d[23:8]};
				end else begin
					status_d = u16d_pkg::StatusOk;
					code_d   = '0;
				end
			end
			phase_d  = PhIdle;
			held_d   = '0;
			start_d  = 1'b1;
			active_d = native_q;
		end
	end

	// stream state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PhIdle;
			held_q   <= '0;
			start_q  <= 1'b1;
			active_q <= u16d_pkg::NativeRst;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q  <= phase_d;
				held_q   <= held_d;
				start_q  <= start_d;
				active_q <= active_d;
			end
			if (adv_s1) begin
				valid_s2 <= emit;
			end else if (cp_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			code_s2   <= code_d;
			status_s2 <= status_d;
			done_s2   <= eos_s1;
		end
	end

	assign cp_ch.valid       = valid_s2;
	assign cp_ch.code_point  = code_s2;
	assign cp_ch.status      = status_s2;
	assign cp_ch.stream_done = done_s2;

	// checks
	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_ch.valid && cp_ch.status == u16d_pkg::StatusTruncated) |-> cp_ch.stream_done)
		else $error("truncated status on a result that does not end the stream");

	a_eos_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eos_s1) |=> (phase_q == PhIdle && start_q && held_q == '0))
		else $error("stream state not restarted after last byte");

	a_eos_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eos_s1) |=> (cp_ch.valid && cp_ch.stream_done))
		else $error("last byte gave no result");

	a_no_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		cp_ch.valid |-> (cp_ch.status == u16d_pkg::StatusOk ||
			cp_ch.status == u16d_pkg::StatusMalformed ||
			cp_ch.status == u16d_pkg::StatusTruncated))
		else $error("undefined status code");

endmodule

`default_nettype wire

// ===== tb/sv/utf16_byte_stream_decoder_test.sv =====
// utf16_byte_stream_decoder_test: self-checking bench for the utf-16 byte stream decoder
// drives random byte streams, predicts code points in a local decoder and checks results
// depends on u16d_pkg, the channel interfaces in u16d_ifs and the decoder top level

module utf16_byte_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ByteW   = u16d_pkg::ByteW;
	localparam int UnitW   = u16d_pkg::UnitW;
	localparam int HeldW   = u16d_pkg::HeldW;
	localparam int CodeW   = u16d_pkg::CodeW;
	localparam int StatusW = u16d_pkg::StatusW;
	localparam int AddrW   = u16d_pkg::AddrW;
	localparam int DataW   = u16d_pkg::DataW;

	localparam int CycleLimit = 400000;
	localparam logic [AddrW-1:0] NativeAddr = AddrW'(4 * u16d_pkg::RegNative);

	typedef enum logic [1:0] {
		PhIdle     = 2'd0,
		PhByte     = 2'd1,
		PhHigh     = 2'd2,
		PhHighByte = 2'd3
	} dec_phase_t;

	typedef struct {
		logic [ByteW-1:0] data_byte;
		logic             end_of_stream;
	} byte_req_t;

	typedef struct {
		logic [CodeW-1:0]   code_point;
		logic [StatusW-1:0] status;
		logic               stream_done;
	} code_point_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [AddrW-1:0]   paddr;
	logic [DataW-1:0]   pwdata;
	logic [DataW-1:0]   prdata;
	logic               pready;

	u16d_byte_if byte_ch ();
	u16d_cp_if   cp_ch ();

	utf16_byte_stream_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.byte_ch (byte_ch),
		.cp_ch   (cp_ch)
	);

	byte_req_t   byte_requests[$];
	code_point_t code_points_due[$];
	code_point_t oldest;

	dec_phase_t       dec_phase;
	logic [HeldW-1:0] held_bytes;
	logic             at_start;
	logic             active_le;
	logic             native_cfg;

	int   errors = 0;
	int   cycles = 0;
	int   bytes_queued = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   stall_req = 0;
	int   stall_left = 0;
	logic idle_on = 1'b1;
	logic byte_fired = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [UnitW-1:0] join_bytes(input logic [ByteW-1:0] first,
		input logic [ByteW-1:0] second, input logic le);
		return le ? {second, first} : {first, second};
	endfunction

	task automatic restart_stream();
		dec_phase = PhIdle;
		held_bytes = '0;
		at_start = 1'b1;
		active_le = native_cfg;
	endtask

	task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
		logic [UnitW-1:0] first;
		logic [UnitW-1:0] unit;
		logic [UnitW-1:0] hi;
		logic             mark;
		logic             got;
		code_point_t      res;
		mark = 1'b0;
		got = 1'b0;
		res = '{code_point: '0, status: u16d_pkg::StatusOk, stream_done: 1'b0};
		case (dec_phase)
			PhIdle: begin
				held_bytes[ByteW-1:0] = b;
				dec_phase = PhByte;
			end
			PhByte: begin
				first = UnitW'(held_bytes[ByteW-1:0]);
				if (at_start) begin
					at_start = 1'b0;
					if (first[ByteW-1:0] == u16d_pkg::BomFe && b == u16d_pkg::BomFf) begin
						active_le = 1'b0;
						mark = 1'b1;
					end else if (first[ByteW-1:0] == u16d_pkg::BomFf &&
						b == u16d_pkg::BomFe) begin
						active_le = 1'b1;
						mark = 1'b1;
					end else begin
						active_le = native_cfg;
					end
				end
				dec_phase = PhIdle;
				if (!mark) begin
					unit = join_bytes(first[ByteW-1:0], b, active_le);
					if ((unit & u16d_pkg::SurrMask) != u16d_pkg::SurrBase) begin
						res.code_point = CodeW'(unit);
						got = 1'b1;
					end else if (unit[10]) begin
						res.code_point = CodeW'(unit);
						res.status = u16d_pkg::StatusMalformed;
						got = 1'b1;
					end else begin
						held_bytes = {unit, 8'h00};
						dec_phase = PhHigh;
					end
				end
			end
			PhHigh: begin
				held_bytes[ByteW-1:0] = b;
				dec_phase = PhHighByte;
			end
			default: begin
				hi = held_bytes[HeldW-1:ByteW];
				unit = join_bytes(held_bytes[ByteW-1:0], b, active_le);
				res.code_point = u16d_pkg::PlaneBase
					+ (CodeW'(unit) - CodeW'(u16d_pkg::LowBase))
					+ ((CodeW'(hi) - CodeW'(u16d_pkg::SurrBase)) << 10);
				res.status = ((unit & u16d_pkg::PairMask) == u16d_pkg::LowBase) ?
					u16d_pkg::StatusOk : u16d_pkg::StatusMalformed;
				got = 1'b1;
				dec_phase = PhIdle;
				held_bytes = '0;
			end
		endcase
		if (last) begin
			if (!got) begin
				got = 1'b1;
				if (dec_phase == PhByte || dec_phase == PhHighByte) begin
					res.status = u16d_pkg::StatusTruncated;
					res.code_point = '0;
				end else if (dec_phase == PhHigh) begin
					res.status = u16d_pkg::StatusMalformed;
					res.code_point = CodeW'(held_bytes[HeldW-1:ByteW]);
				end
			end
			res.stream_done = 1'b1;
			restart_stream();
		end
		if (got)
			code_points_due = {code_points_due, res};
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			byte_fired = 1'b0;
		end else begin
			if (cp_ch.valid && cp_ch.ready) begin
				if (code_points_due.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h/%0d/%0b", $time,
						cp_ch.code_point, cp_ch.status, cp_ch.stream_done);
					errors++;
				end else begin
					oldest = code_points_due.pop_front();
					if (cp_ch.code_point !== oldest.code_point) begin
						$display("%0t: code_point mismatch: expected %h, actual %h", $time,
							oldest.code_point, cp_ch.code_point);
						errors++;
					end
					if (cp_ch.status !== oldest.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d", $time,
							oldest.status, cp_ch.status);
						errors++;
					end
					if (cp_ch.stream_done !== oldest.stream_done) begin
						$display("%0t: stream_done mismatch: expected %0b, actual %0b", $time,
							oldest.stream_done, cp_ch.stream_done);
						errors++;
					end
				end
			end
			byte_fired = byte_ch.valid && byte_ch.ready;
			if (byte_fired) begin
				void'(byte_requests.pop_front());
				decode_byte(byte_ch.data_byte, byte_ch.end_of_stream);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_req != 0) begin
			stall_left = stall_req;
			stall_req = 0;
		end else if (stall_left != 0) begin
			stall_left--;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
		end else if (byte_ch.valid && !byte_fired) begin
		end else if (send_gap != 0) begin
			send_gap--;
			byte_ch.valid <= 1'b0;
		end else if (idle_on && byte_requests.size() != 0 && $urandom_range(0, 99) < 12) begin
			send_gap = $urandom_range(0, 8);
			byte_ch.valid <= 1'b0;
		end else if (byte_requests.size() != 0) begin
			byte_ch.valid <= 1'b1;
			byte_ch.data_byte <= byte_requests[0].data_byte;
			byte_ch.end_of_stream <= byte_requests[0].end_of_stream;
		end else begin
			byte_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n || stall_left != 0) begin
			cp_ch.ready <= 1'b0;
		end else if (recv_gap != 0) begin
			recv_gap--;
			cp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 12) begin
			recv_gap = $urandom_range(0, 8);
			cp_ch.ready <= 1'b0;
		end else begin
			cp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
		byte_req_t r;
		r.data_byte = b;
		r.end_of_stream = last;
		byte_requests = {byte_requests, r};
		bytes_queued++;
	endtask

	task automatic push_unit(input logic [UnitW-1:0] u, input logic le, input logic last);
		if (le) begin
			push_byte(u[7:0], 1'b0);
			push_byte(u[15:8], last);
		end else begin
			push_byte(u[15:8], 1'b0);
			push_byte(u[7:0], last);
		end
	endtask

	task automatic push_stream(input int n_units);
		int               mark_kind;
		int               pick;
		int               ending;
		int               start;
		logic             le;
		logic [UnitW-1:0] u;
		start = bytes_queued;
		mark_kind = $urandom_range(0, 3);
		le = native_cfg;
		if (mark_kind == 1) begin
			push_byte(u16d_pkg::BomFe, 1'b0);
			push_byte(u16d_pkg::BomFf, 1'b0);
			le = 1'b0;
		end else if (mark_kind == 2) begin
			push_byte(u16d_pkg::BomFf, 1'b0);
			push_byte(u16d_pkg::BomFe, 1'b0);
			le = 1'b1;
		end
		for (int i = 0; i < n_units; i++) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				u = UnitW'($urandom);
				if ((u & u16d_pkg::SurrMask) == u16d_pkg::SurrBase)
					u ^= 16'h4000;
				push_unit(u, le, 1'b0);
			end else if (pick == 4) begin
				push_unit(UnitW'($urandom_range(0, 127)), le, 1'b0);
			end else if (pick <= 7) begin
				push_unit(u16d_pkg::SurrBase + UnitW'($urandom_range(0, 1023)), le, 1'b0);
				push_unit(u16d_pkg::LowBase + UnitW'($urandom_range(0, 1023)), le, 1'b0);
			end else if (pick == 8) begin
				push_unit(u16d_pkg::LowBase + UnitW'($urandom_range(0, 1023)), le, 1'b0);
			end else begin
				push_unit(u16d_pkg::SurrBase + UnitW'($urandom_range(0, 1023)), le, 1'b0);
				push_unit(UnitW'($urandom), le, 1'b0);
			end
		end
		ending = $urandom_range(0, 9);
		if (ending == 7)
			push_byte(ByteW'($urandom), 1'b0);
		else if (ending == 8)
			push_unit(u16d_pkg::SurrBase + UnitW'($urandom_range(0, 1023)), le, 1'b0);
		if (bytes_queued == start)
			push_byte(ByteW'($urandom), 1'b0);
		byte_requests[$].end_of_stream = 1'b1;
	endtask

	task automatic drain();
		while (byte_requests.size() != 0 || code_points_due.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic set_native(input logic v);
		logic [DataW-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= NativeAddr;
		pwdata <= DataW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		native_cfg = v;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== DataW'(v)) begin
			$display("%0t: native order readback mismatch: expected %h, actual %h", $time,
				DataW'(v), rd);
			errors++;
		end
	endtask

	task automatic run_random(input int target, input logic allow_idle);
		int stop_at;
		int n;
		stop_at = bytes_queued + target;
		while (bytes_queued < stop_at) begin
			if (byte_requests.size() > 16) begin
				@(negedge clk);
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, 12);
					for (int i = 0; i < n; i++)
						push_byte(ByteW'($urandom), $urandom_range(0, 5) == 0);
				end else begin
					n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
					push_stream(n);
				end
				if (allow_idle && $urandom_range(0, 11) == 0)
					idle_on = $urandom_range(0, 3) != 0;
				if ($urandom_range(0, 39) == 0)
					drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.end_of_stream = 1'b0;
		cp_ch.ready = 1'b0;
		native_cfg = u16d_pkg::NativeRst;
		restart_stream();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// little-endian mark, ascii, then a pair
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFE, 1'b0);
		push_unit(16'h0041, 1'b1, 1'b0);
		push_unit(16'hD83D, 1'b1, 1'b0);
		push_unit(16'hDE00, 1'b1, 1'b1);
		// stream that is only a big-endian mark
		push_byte(8'hFE, 1'b0);
		push_byte(8'hFF, 1'b1);
		// native order: max unit, leading low, high without low, odd last byte
		push_unit(16'hFFFF, 1'b1, 1'b0);
		push_unit(16'hDC00, 1'b1, 1'b0);
		push_unit(16'hD800, 1'b1, 1'b0);
		push_unit(16'h0041, 1'b1, 1'b0);
		push_byte(8'h00, 1'b1);
		// high surrogate left at the end
		push_unit(16'hD800, 1'b1, 1'b1);
		// odd byte after a pending high surrogate
		push_unit(16'hD800, 1'b1, 1'b0);
		push_byte(8'h12, 1'b1);
		drain();

		set_native(1'b0);
		push_unit(16'hDBFF, 1'b0, 1'b0);
		push_unit(16'hDFFF, 1'b0, 1'b1);
		push_unit(16'hD800, 1'b0, 1'b0);
		push_unit(16'hDC00, 1'b0, 1'b1);
		run_random(600, 1'b1);
		drain();

		// receiver holds off while the sender keeps pushing
		set_native(1'b1);
		idle_on = 1'b0;
		@(negedge clk);
		stall_req = 300;
		while (bytes_queued < 780)
			push_stream($urandom_range(1, 8));
		drain();

		set_native(1'b0);
		idle_on = 1'b1;
		run_random(550, 1'b1);
		drain();

		set_native(1'b1);
		idle_on = 1'b0;
		run_random(500, 1'b0);
		drain();
		repeat (10) @(negedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/u16d_pkg.sv
hdl/u16d_ifs.sv
hdl/utf16_byte_stream_decoder.sv
tb/sv/utf16_byte_stream_decoder_test.sv
